/* rtl/tksi_pkg.sv */
// Package for the top-k sorted insertion list: field widths, operation codes
// and the record and cell types used across the design.
// Has no dependencies; every other file imports it.
package tksi_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 64;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned TOPIC_W   = 32;
  localparam int unsigned DATE_W    = 32;
  localparam int unsigned BOARD_W   = 16;
  localparam int unsigned RANK_W    = 6;
  localparam int unsigned OUT_CNT_W = 7;

  localparam int unsigned S_DATA_W = 120;
  localparam int unsigned M_DATA_W = 128;

  // Entries per group in the first stage of the rank select
  localparam int unsigned SEL_GRP = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [TOPIC_W-1:0]        topic;
    logic [DATE_W-1:0]         date;
    logic [BOARD_W-1:0]        board;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } cell_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic   clear;
    logic   insert;
    entry_t ent;
  } cell_ctl_t;

endpackage

/* rtl/tksi_cell.sv */
// One rank of the sorted list: holds one record and its valid bit.
// Depends on tksi_pkg for the record and control types.
module tksi_cell
  import tksi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  cell_t     left_i,
  input  logic      left_take_i,
  output cell_t     cell_o,
  output logic      take_o
);

  logic   valid_q, valid_d;
  entry_t ent_q, ent_d;

  // Give way to the new record when empty or strictly outscored
  assign take_o = !valid_q || ($signed(ctl_i.ent.score) > $signed(ent_q.score));

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.insert && take_o) begin
      if (left_take_i) begin
        // shift down from the neighbour above
        valid_d = left_i.valid;
        ent_d   = left_i.ent;
      end else begin
        valid_d = 1'b1;
        ent_d   = ctl_i.ent;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.ent   = ent_q;

endmodule

/* rtl/tksi_rank_sel.sv */
// Two-stage select of one cell by rank: group select into registers, then
// a select among the group registers. Depends on tksi_pkg.
module tksi_rank_sel
  import tksi_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  cell_t             cells_i [LIST_DEPTH],
  input  logic [RANK_W-1:0] rank_i,
  input  logic              grp_en_i,
  output cell_t             sel_o
);

  localparam int unsigned GRP_W = $clog2(SEL_GRP);
  localparam int unsigned NGRP  = (LIST_DEPTH + SEL_GRP - 1) / SEL_GRP;

  cell_t grp_q [NGRP];
  cell_t grp_d [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < SEL_GRP; k++) begin
        if ((g * SEL_GRP + k) < LIST_DEPTH && rank_i[GRP_W-1:0] == GRP_W'(k)) begin
          grp_d[g] = cells_i[g * SEL_GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_en_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    sel_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (int'(rank_i[RANK_W-1:GRP_W]) == g) begin
        sel_o = grp_q[g];
      end
    end
  end

endmodule

/* rtl/top_k_sorted_insert.sv */
// Top level of the top-k sorted insertion list: stream ports, operation
// sequencer, the row of list cells and the result register.
// Depends on tksi_pkg, tksi_cell and tksi_rank_sel.
//
//  channel   dir  tdata fields (low bit up)                         tuser
//  s_axis    in   item_score, item_topic, item_date, item_board,    func
//                 read_rank, zero pad to 120 bits
//  m_axis    out  entry_score, entry_topic, entry_date, entry_board, entry_valid
//                 insert_rank, held_count, zero pad to 128 bits
//
// Each item passes through these steps in order, and the input takes no new
// item until the last step is done: one in which it is offered and captured,
// one in which the cells clear or, for an insert, compare against the broadcast
// score and shift or load, while the first rank-select stage loads, and one to
// fill the result register, which raises m_axis_tvalid. A result waiting on m_axis_tready
// stalls the next item in the last of these steps only. Reset clears every
// valid bit and the held count at once; a clear item does the same in its middle step.
module top_k_sorted_insert
  import tksi_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // item_score[31:0], item_topic[63:32], item_date[95:64],
  // item_board[111:96], read_rank[117:112], zero[119:118]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [FUNC_W-1:0]   s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // entry_score[31:0], entry_topic[63:32], entry_date[95:64],
  // entry_board[111:96], insert_rank[118:112], held_count[125:119], zero[127:126]
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // entry_valid[0]
  output logic [0:0]          m_axis_tuser
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned EXT_W = CNT_W + OUT_CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  state_e            state_q;
  func_e             func_q;
  entry_t            ent_q;
  logic [RANK_W-1:0] rank_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  ins_q, ins_d;

  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;
  logic                m_user_q;

  cell_ctl_t ctl;
  cell_t     cells     [LIST_DEPTH];
  cell_t     left_cell [LIST_DEPTH];
  logic      take      [LIST_DEPTH];
  logic      left_take [LIST_DEPTH];
  cell_t     sel;

  logic             s_fire;
  logic             in_exec;
  logic             pos_score;
  logic [CNT_W-1:0] first_pos;
  logic             res_load;

  logic                  out_valid;
  entry_t                out_ent;
  logic [EXT_W-1:0]      ins_ext;
  logic [EXT_W-1:0]      cnt_ext;
  logic [M_DATA_W-1:0]   out_data;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_exec       = (state_q == ST_EXEC);

  // Fill the result register once it is free or being emptied
  assign res_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // Only strictly positive scores ever enter the list
  assign pos_score  = ($signed(ent_q.score) > 0);
  assign ctl.clear  = in_exec && (func_q == FUNC_CLEAR);
  assign ctl.insert = in_exec && (func_q == FUNC_INSERT) && pos_score;
  assign ctl.ent    = ent_q;

  // Row of cells: each one sees the broadcast record and its upper neighbour
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_cell[i] = '0;
      assign left_take[i] = 1'b0;
    end else begin : g_body
      assign left_cell[i] = cells[i-1];
      assign left_take[i] = take[i-1];
    end

    tksi_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      (left_cell[i]),
      .left_take_i (left_take[i]),
      .cell_o      (cells[i]),
      .take_o      (take[i])
    );
  end

  tksi_rank_sel #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_rank_sel (
    .clk_i    (clk_i),
    .cells_i  (cells),
    .rank_i   (rank_q),
    .grp_en_i (in_exec),
    .sel_o    (sel)
  );

  // Take flags are monotonic down the row: encode the single first one
  always_comb begin
    first_pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (take[i] && !left_take[i]) begin
        first_pos = first_pos | CNT_W'(i);
      end
    end
  end

  // Nothing lands when the last rank keeps its place
  always_comb begin
    ins_d = DEPTH_CNT;
    if (func_q == FUNC_INSERT && pos_score && take[LIST_DEPTH-1]) begin
      ins_d = first_pos;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl.clear) begin
      cnt_d = '0;
    end else if (ctl.insert && !cells[LIST_DEPTH-1].valid) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end
  end

  // Result word; entry fields read as zero unless a read hit a held rank
  assign out_valid = (func_q == FUNC_READ) && sel.valid;
  assign out_ent   = out_valid ? sel.ent : '0;
  assign ins_ext   = EXT_W'(ins_q);
  assign cnt_ext   = EXT_W'(cnt_q);
  assign out_data  = {2'b00, cnt_ext[OUT_CNT_W-1:0], ins_ext[OUT_CNT_W-1:0],
                      out_ent.board, out_ent.date, out_ent.topic, out_ent.score};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      func_q    <= FUNC_CLEAR;
      ent_q     <= '0;
      rank_q    <= '0;
      cnt_q     <= '0;
      ins_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            // capture the item and its operation
            func_q         <= func_e'(s_axis_tuser);
            ent_q.score    <= s_axis_tdata[31:0];
            ent_q.topic    <= s_axis_tdata[63:32];
            ent_q.date     <= s_axis_tdata[95:64];
            ent_q.board    <= s_axis_tdata[111:96];
            rank_q         <= s_axis_tdata[117:112];
            state_q        <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cnt_q   <= cnt_d;
          ins_q   <= ins_d;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free or being emptied
          if (res_load) begin
            m_data_q  <= out_data;
            m_user_q  <= out_valid;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  // Held count and the occupancy of the last rank agree
  a_full_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == DEPTH_CNT) == cells[LIST_DEPTH-1].valid)
    else $error("held count disagrees with last rank occupancy");

  // A clear zeroes the held count and empties the first rank by the next cycle
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear |=> (cnt_q == '0) && !cells[0].valid)
    else $error("clear left entries behind");

  // An insert into a list that is not full grows it by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.insert && !cells[LIST_DEPTH-1].valid |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
    else $error("insert did not grow the held count");

endmodule
